### sv/patch_jump_table_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the patch jump table engine
// Shared shapes for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PATCH_JUMP_TABLE_ENGINE_ASSERT_SVH
`define PATCH_JUMP_TABLE_ENGINE_ASSERT_SVH

// Condition in this cycle implies consequent in the same cycle
`define PJTE_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// Condition in this cycle implies consequent in the next cycle
`define PJTE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (conseq)) else $error(msg);

// Condition must never hold
`define PJTE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        !(cond)) else $error(msg);

`endif

### sv/pjte_pkg.sv
// ----------------------------------------------------------------------------
// pjte_pkg
// Types and codes shared by the jump table engine and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pjte_pkg;

    localparam int WORD_W = 64;
    localparam int LEN_W  = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_STACK  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS = 2'd2;

    localparam logic [WORD_W-1:0] WINDOW_LOW_RESET = {WORD_W{1'b1}};

    // One stored redirection
    typedef struct packed {
        logic [WORD_W-1:0] orig_addr;
        logic [WORD_W-1:0] start_addr;
        logic [WORD_W-1:0] end_addr;
    } entry_t;

    // Query travelling down the row of cells
    typedef struct packed {
        logic              valid;
        logic              is_lookup;
        logic              found;
        logic              hit;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] target;
    } token_t;

    // One finished result
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [WORD_W-1:0] target;
        logic              hit;
    } result_t;

endpackage

`default_nettype wire

### sv/pjte_cell.sv
// ----------------------------------------------------------------------------
// pjte_cell
// One table slot: holds an entry, shifts it on insert, and matches the
// passing query against it before handing the query on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pjte_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic [CNT_W-1:0]    count,
    input  pjte_pkg::entry_t    entry_in,
    output pjte_pkg::entry_t    entry_out,
    input  pjte_pkg::token_t    tok_in,
    output pjte_pkg::token_t    tok_out
);
    import pjte_pkg::*;

    entry_t entry_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   live;

    // Slot holds a stored entry only while its index is below the fill count
    assign live = (CNT_W'(CELL_INDEX) < count);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && live)
        begin
            if (tok_in.is_lookup)
            begin
                // first match down the row is the newest entry
                if (!tok_in.found && (entry_reg.orig_addr == tok_in.word))
                begin
                    tok_next.found  = 1'b1;
                    tok_next.target = entry_reg.start_addr;
                end
            end
            else if ((tok_in.word >= entry_reg.start_addr) &&
                     (tok_in.word < entry_reg.end_addr))
            begin
                tok_next.hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign entry_out = entry_reg;
    assign tok_out   = tok_reg;

endmodule

`default_nettype wire

### sv/patch_jump_table_engine.sv
// ----------------------------------------------------------------------------
// patch_jump_table_engine
// Function redirection table: clear, insert, lookup by old address, and stack word
// range check, built as a row of table cells that a query walks through.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  --------  ---------  -------------------  ----------------------------------
//  in        sink       in_valid / in_stall  opcode, address_word, new_start,
//                                            new_length
//  out       source     out_valid/out_stall  status, jump_target, on_stack_hit
//  cfg       sink       cfg_valid/cfg_ready  cfg_data (address bias)
//
//  Clear and insert finish in the cycle they are accepted; their result is
//  registered, and a new request may follow every cycle while no result
//  is parked in the skid register. Lookup and stack check walk the row of
//  TABLE_ENTRIES cells, one cell per cycle, so the row length sets how long
//  they take; no new request is taken until the query leaves the row.
//  Reset empties the table and the window at once; no clearing pass.
//  A stalled result parks in a skid register, so one more request is taken.
//
`timescale 1ns / 1ps
`default_nettype none
`include "patch_jump_table_engine_assert.svh"

module patch_jump_table_engine #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pjte_pkg::OP_W-1:0]     opcode,
    input  logic [pjte_pkg::WORD_W-1:0]   address_word,
    input  logic [pjte_pkg::WORD_W-1:0]   new_start,
    input  logic [pjte_pkg::LEN_W-1:0]    new_length,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pjte_pkg::ST_W-1:0]     status,
    output logic [pjte_pkg::WORD_W-1:0]   jump_target,
    output logic                          on_stack_hit,
    // bias register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pjte_pkg::WORD_W-1:0]   cfg_data
);
    import pjte_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] bias_reg;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [WORD_W-1:0] win_low_reg,  win_low_next;
    logic [WORD_W-1:0] win_high_reg, win_high_next;
    logic              busy_reg,     busy_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg,  out_res_next;
    logic              skid_valid_reg, skid_valid_next;
    result_t           skid_res_reg, skid_res_next;

    logic              acc;
    logic              full;
    logic              shift_en;
    entry_t            new_entry;
    token_t            launch_tok;
    token_t            exit_tok;
    logic              tok_exit;
    logic              win_ok;
    logic              done;
    result_t           done_res;
    logic              out_free;

    entry_t            cell_entry [TABLE_ENTRIES];
    token_t            cell_tok   [TABLE_ENTRIES];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Hold requests while a query is in the row or a result is parked
    assign in_stall  = busy_reg | skid_valid_reg;
    assign acc       = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    assign full      = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign shift_en  = acc && (opcode == OP_INSERT) && !full;

    // New entry enters cell 0; older entries move one cell down
    always_comb
    begin
        new_entry.orig_addr  = address_word + bias_reg;
        new_entry.start_addr = new_start;
        new_entry.end_addr   = new_start + {{(WORD_W-LEN_W){1'b0}}, new_length};
    end

    // Query token for lookup and stack check
    always_comb
    begin
        launch_tok           = '0;
        launch_tok.valid     = acc && ((opcode == OP_LOOKUP) || (opcode == OP_STACK));
        launch_tok.is_lookup = (opcode == OP_LOOKUP);
        launch_tok.word      = address_word;
    end

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        entry_t entry_in;
        token_t tok_in;

        if (gi == 0)
        begin : g_head
            assign entry_in = new_entry;
            assign tok_in   = launch_tok;
        end
        else
        begin : g_body
            assign entry_in = cell_entry[gi-1];
            assign tok_in   = cell_tok[gi-1];
        end

        pjte_cell #(
            .CELL_INDEX (gi),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .count     (count_reg),
            .entry_in  (entry_in),
            .entry_out (cell_entry[gi]),
            .tok_in    (tok_in),
            .tok_out   (cell_tok[gi])
        );
    end

    assign exit_tok = cell_tok[TABLE_ENTRIES-1];
    assign tok_exit = exit_tok.valid;

    // Window filter for the stack check; an empty table fails it
    assign win_ok = (win_low_reg < win_high_reg) &&
                    (exit_tok.word >= win_low_reg) &&
                    (exit_tok.word < win_high_reg);

    // ------------------------------------------------------------------
    // Table bookkeeping and completion
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next    = count_reg;
        win_low_next  = win_low_reg;
        win_high_next = win_high_reg;
        busy_next     = busy_reg;
        done          = 1'b0;
        done_res      = '0;

        if (acc)
        begin
            case (opcode)
                OP_CLEAR:
                begin
                    count_next    = '0;
                    win_low_next  = WINDOW_LOW_RESET;
                    win_high_next = '0;
                    done          = 1'b1;
                end
                OP_INSERT:
                begin
                    done = 1'b1;
                    if (full)
                    begin
                        done_res.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (new_start < win_low_reg)
                        begin
                            win_low_next = new_start;
                        end
                        if (new_entry.end_addr > win_high_reg)
                        begin
                            win_high_next = new_entry.end_addr;
                        end
                    end
                end
                OP_LOOKUP, OP_STACK:
                begin
                    busy_next = 1'b1;
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
        else if (tok_exit)
        begin
            // query leaves the last cell: drop busy and form the result
            busy_next = 1'b0;
            done      = 1'b1;
            if (exit_tok.is_lookup)
            begin
                done_res.status = exit_tok.found ? ST_OK : ST_MISS;
                done_res.target = exit_tok.found ? exit_tok.target : '0;
            end
            else
            begin
                done_res.hit = exit_tok.hit & win_ok;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = done;
                skid_res_next   = done_res;
            end
            else
            begin
                out_valid_next = done;
                out_res_next   = done_res;
            end
        end
        else if (done)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = done_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg       <= '0;
            count_reg      <= '0;
            win_low_reg    <= WINDOW_LOW_RESET;
            win_high_reg   <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
            skid_valid_reg <= 1'b0;
            skid_res_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                bias_reg <= cfg_data;
            end
            count_reg      <= count_next;
            win_low_reg    <= win_low_next;
            win_high_reg   <= win_high_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
            skid_valid_reg <= skid_valid_next;
            skid_res_reg   <= skid_res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign jump_target  = out_res_reg.target;
    assign on_stack_hit = out_res_reg.hit;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PJTE_ASSERT_NEVER(a_count_range, count_reg > CNT_W'(TABLE_ENTRIES), "fill count overrun")
    `PJTE_ASSERT_SAME(a_exit_busy, tok_exit, busy_reg, "query left the row while not busy")
    `PJTE_ASSERT_NEVER(a_skid_clash, done && skid_valid_reg, "result completed with skid full")
    `PJTE_ASSERT_NEXT(a_insert_count, shift_en, count_reg == $past(count_reg) + 1'b1, "insert lost")

endmodule

`default_nettype wire
